// File: rtl/ebt_pkg.sv
// ebt_pkg: constants, types and the arctangent table of the edge balance torque block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
package ebt_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int MAX_STAGES = 24;
	localparam int NSTG = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
	localparam int XW = 28;   // cordic x/y width (16b input * 256, growth)
	localparam int ZW = 20;   // angle accumulator, Q.16 radians
	localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;
	localparam logic signed [ZW:0] TWO_PI_Q16 = 21'sd411775;
	localparam logic signed [ZW-1:0] QPI_Q16 = 20'sd51472;
	localparam logic signed [ZW-1:0] TQPI_Q16 = 20'sd154416;
	localparam logic signed [14:0] TILT_MAX = 15'sd12868;
	localparam logic signed [19:0] D2R_Q24 = 20'sd292818;
	localparam logic signed [25:0] RPM_Q28 = 26'sd28110497;

	typedef enum logic [1:0] {ST_EDGE = 2'd0, ST_NOGRAV = 2'd1, ST_NOEDGE = 2'd2} status_t;
	typedef enum logic [1:0] {
		REG_GX = 2'd0, REG_GY = 2'd1, REG_GZ = 2'd2, REG_MING = 2'd3
	} reg_idx_t;

	// payload carried down the chain beside the cordic vector
	typedef struct packed {
		status_t status;
		logic [1:0] axis;
		logic [1:0] wsel;
		logic signed [ZW-1:0] ideal;
		logic signed [15:0] rate;
		logic signed [15:0] rpm;
		logic [47:0] gains;
	} side_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0: r = 20'sd51472;
			1: r = 20'sd30386;
			2: r = 20'sd16055;
			3: r = 20'sd8150;
			4: r = 20'sd4091;
			5: r = 20'sd2047;
			6: r = 20'sd1024;
			7: r = 20'sd512;
			8: r = 20'sd256;
			9: r = 20'sd128;
			10: r = 20'sd64;
			11: r = 20'sd32;
			12: r = 20'sd16;
			13: r = 20'sd8;
			14: r = 20'sd4;
			15: r = 20'sd2;
			16: r = 20'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// File: rtl/ebt_cell.sv
// ebt_cell: one vectoring CORDIC micro-rotation with its pipeline register.
// Depends on ebt_pkg.
`timescale 1ns / 1ps
module ebt_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [4:0] idx,
	input logic v_in,
	input ebt_pkg::vec_t vec_in,
	input ebt_pkg::side_t side_in,
	output logic v_q,
	output ebt_pkg::vec_t vec_q,
	output ebt_pkg::side_t side_q
);
	ebt_pkg::vec_t nxt;
	logic signed [ebt_pkg::XW-1:0] ys, xs;

	always_comb begin
		ys = vec_in.y >>> idx;
		xs = vec_in.x >>> idx;
		if (!vec_in.y[ebt_pkg::XW-1]) begin
			nxt.x = vec_in.x + ys;
			nxt.y = vec_in.y - xs;
			nxt.z = vec_in.z + ebt_pkg::atan_q16(int'(idx));
		end else begin
			nxt.x = vec_in.x - ys;
			nxt.y = vec_in.y + xs;
			nxt.z = vec_in.z - ebt_pkg::atan_q16(int'(idx));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= nxt;
			side_q <= side_in;
		end
	end
endmodule

// File: rtl/edge_balance_torque.sv
// edge_balance_torque: edge detection, CORDIC tilt and state-feedback torque.
// Pipeline registers from request accept to result valid: s1, s2, the cordic cells, s3, s4, s5, output.
// Throughput: one request per cycle; the whole pipe advances when the output is free or taken.
// Reset (arst_n low, async): pipe valid bits clear, gains go to 0, min_gravity_sq to 167772.
// Uses ebt_pkg and ebt_cell.
`timescale 1ns / 1ps
module edge_balance_torque (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input logic valid_in,
	output logic ready_in,
	input logic signed [15:0] accel_x,
	input logic signed [15:0] accel_y,
	input logic signed [15:0] accel_z,
	input logic signed [15:0] rate_x,
	input logic signed [15:0] rate_y,
	input logic signed [15:0] rate_z,
	input logic signed [15:0] wheel_a_speed,
	input logic signed [15:0] wheel_b_speed,
	input logic signed [15:0] wheel_c_speed,
	output logic valid_out,
	input logic ready_out,
	output logic [1:0] status,
	output logic [1:0] edge_axis,
	output logic [1:0] wheel_select,
	output logic signed [14:0] tilt_error,
	output logic signed [31:0] torque,
	output logic spin_cw
);
	localparam int N = ebt_pkg::NSTG;
	localparam int XW = ebt_pkg::XW;
	localparam int ZW = ebt_pkg::ZW;

	// ---------------- register file ----------------
	logic [47:0] gx_q, gy_q, gz_q;
	logic [31:0] ming_q;
	ebt_pkg::reg_idx_t ridx;
	assign ridx = ebt_pkg::reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q <= '0;
			gy_q <= '0;
			gz_q <= '0;
			ming_q <= 32'd167772;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				ebt_pkg::REG_GX: gx_q <= pwdata[47:0];
				ebt_pkg::REG_GY: gy_q <= pwdata[47:0];
				ebt_pkg::REG_GZ: gz_q <= pwdata[47:0];
				ebt_pkg::REG_MING: ming_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			ebt_pkg::REG_GX: prdata = {16'd0, gx_q};
			ebt_pkg::REG_GY: prdata = {16'd0, gy_q};
			ebt_pkg::REG_GZ: prdata = {16'd0, gz_q};
			ebt_pkg::REG_MING: prdata = {32'd0, ming_q};
			default: prdata = '0;
		endcase
	end

	// ---------------- global stall ----------------
	// Whole pipe moves when the output slot is empty or being drained.
	logic adv;
	assign adv = !valid_out || ready_out;
	assign ready_in = adv;

	// ---------------- s1: squares ----------------
	// full-scale negative input squares to 2^30, so 31 bits
	logic v_s1;
	logic [30:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [15:0] ax_s1, ay_s1, az_s1, rx_s1, ry_s1, rz_s1, wa_s1, wb_s1, wc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= valid_in;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1 <= 31'(unsigned'(32'(accel_x * accel_x)));
			sqy_s1 <= 31'(unsigned'(32'(accel_y * accel_y)));
			sqz_s1 <= 31'(unsigned'(32'(accel_z * accel_z)));
			ax_s1 <= accel_x; ay_s1 <= accel_y; az_s1 <= accel_z;
			rx_s1 <= rate_x; ry_s1 <= rate_y; rz_s1 <= rate_z;
			wa_s1 <= wheel_a_speed; wb_s1 <= wheel_b_speed; wc_s1 <= wheel_c_speed;
		end
	end

	// ---------------- s2: classify, select plane, pre-rotate ----------------
	logic [31:0] n2;
	logic [41:0] lim;
	logic [2:0] flat;
	ebt_pkg::side_t side_d;
	ebt_pkg::vec_t vec_d;
	logic signed [15:0] py, px;

	always_comb begin
		n2 = 32'(sqx_s1) + 32'(sqy_s1) + 32'(sqz_s1);
		lim = 42'(n2) * 42'd117;
		flat[0] = (42'(sqx_s1) * 42'd1000) < lim;
		flat[1] = (42'(sqy_s1) * 42'd1000) < lim;
		flat[2] = (42'(sqz_s1) * 42'd1000) < lim;
		side_d = '0;
		py = '0;
		px = '0;
		if (n2 < ming_q) begin
			side_d.status = ebt_pkg::ST_NOGRAV;
		end else if (!$onehot(flat)) begin
			side_d.status = ebt_pkg::ST_NOEDGE;
		end else begin
			side_d.status = ebt_pkg::ST_EDGE;
			priority if (flat[0]) begin
				py = az_s1; px = ay_s1; side_d.rate = rx_s1; side_d.rpm = wb_s1;
				side_d.gains = gx_q; side_d.axis = 2'd0; side_d.wsel = 2'd1;
			end else if (flat[1]) begin
				py = ax_s1; px = az_s1; side_d.rate = ry_s1; side_d.rpm = wa_s1;
				side_d.gains = gy_q; side_d.axis = 2'd1; side_d.wsel = 2'd0;
			end else begin
				py = ay_s1; px = ax_s1; side_d.rate = rz_s1; side_d.rpm = wc_s1;
				side_d.gains = gz_q; side_d.axis = 2'd2; side_d.wsel = 2'd2;
			end
		end
		if (!px[15]) side_d.ideal = py[15] ? -ebt_pkg::QPI_Q16 : ebt_pkg::QPI_Q16;
		else side_d.ideal = py[15] ? -ebt_pkg::TQPI_Q16 : ebt_pkg::TQPI_Q16;
		// left half plane: rotate by pi first
		vec_d.x = XW'(signed'({px, 8'd0}));
		vec_d.y = XW'(signed'({py, 8'd0}));
		vec_d.z = '0;
		if (px[15]) begin
			vec_d.x = -vec_d.x;
			vec_d.y = -vec_d.y;
			vec_d.z = py[15] ? -ebt_pkg::PI_Q16 : ebt_pkg::PI_Q16;
		end
	end

	logic v_s2;
	ebt_pkg::vec_t vec_s2;
	ebt_pkg::side_t side_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s2 <= vec_d;
			side_s2 <= side_d;
		end
	end

	// ---------------- cordic chain ----------------
	logic [N:0] cv;
	ebt_pkg::vec_t cvec [N+1];
	ebt_pkg::side_t cside [N+1];
	assign cv[0] = v_s2;
	assign cvec[0] = vec_s2;
	assign cside[0] = side_s2;

	for (genvar g = 0; g < N; g++) begin : g_cell
		ebt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .idx(5'(g)),
			.v_in(cv[g]), .vec_in(cvec[g]), .side_in(cside[g]),
			.v_q(cv[g+1]), .vec_q(cvec[g+1]), .side_q(cside[g+1])
		);
	end

	// ---------------- s3: wrap, round, saturate tilt ----------------
	logic signed [ZW:0] err, errw;
	logic signed [ZW-3:0] tr;
	logic signed [14:0] tilt_d;
	always_comb begin
		err = ZW'(0) + (ZW+1)'(cvec[N].z) - (ZW+1)'(cside[N].ideal);
		errw = err;
		if (err > (ZW+1)'(ebt_pkg::PI_Q16)) errw = err - ebt_pkg::TWO_PI_Q16;
		else if (err < -(ZW+1)'(ebt_pkg::PI_Q16)) errw = err + ebt_pkg::TWO_PI_Q16;
		tr = (ZW-2)'((errw + (ZW+1)'(8)) >>> 4);
		if (tr > (ZW-2)'(ebt_pkg::TILT_MAX)) tilt_d = ebt_pkg::TILT_MAX;
		else if (tr < -(ZW-2)'(ebt_pkg::TILT_MAX)) tilt_d = -ebt_pkg::TILT_MAX;
		else tilt_d = 15'(tr);
	end

	logic v_s3;
	ebt_pkg::side_t side_s3;
	logic signed [14:0] tilt_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= cv[N];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= cside[N];
			tilt_s3 <= tilt_d;
		end
	end

	// ---------------- s4: scale rate and rpm to radians ----------------
	logic v_s4;
	ebt_pkg::side_t side_s4;
	logic signed [14:0] tilt_s4;
	logic signed [35:0] rrad_s4;
	logic signed [41:0] wrad_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			tilt_s4 <= tilt_s3;
			rrad_s4 <= 36'(side_s3.rate) * 36'(ebt_pkg::D2R_Q24);
			wrad_s4 <= 42'(side_s3.rpm) * 42'(ebt_pkg::RPM_Q28);
		end
	end

	// ---------------- s5: gain products ----------------
	// wheel term: 16 x 42 bits, split in two 16 x 21 partial products
	logic v_s5;
	ebt_pkg::side_t side_s5;
	logic signed [14:0] tilt_s5;
	logic signed [31:0] p0_s5;
	logic signed [51:0] p1_s5;
	logic signed [37:0] p2h_s5;
	logic signed [36:0] p2l_s5;
	logic signed [15:0] k0, k1, k2;
	assign k0 = side_s4.gains[15:0];
	assign k1 = side_s4.gains[31:16];
	assign k2 = side_s4.gains[47:32];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			tilt_s5 <= tilt_s4;
			p0_s5 <= 32'(k0) * 32'(tilt_s4);
			p1_s5 <= 52'(k1) * 52'(rrad_s4);
			p2h_s5 <= 38'(k2) * 38'(signed'(wrad_s4[41:21]));
			p2l_s5 <= 37'(k2) * 37'(signed'({1'b0, wrad_s4[20:0]}));
		end
	end

	// ---------------- s6: sum, negate, round, saturate ----------------
	logic signed [63:0] sum, neg, rs;
	logic signed [31:0] tq;
	always_comb begin
		sum = (64'(p0_s5) <<< 16) + 64'(p1_s5) + (64'(p2h_s5) <<< 21) + 64'(p2l_s5);
		neg = -sum;
		rs = (neg + 64'sd8388608) >>> 24;
		if (rs > 64'sd2147483647) tq = 32'sh7fffffff;
		else if (rs < -64'sd2147483648) tq = 32'sh80000000;
		else tq = 32'(rs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (adv) valid_out <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			status <= side_s5.status;
			if (side_s5.status == ebt_pkg::ST_EDGE) begin
				edge_axis <= side_s5.axis;
				wheel_select <= side_s5.wsel;
				tilt_error <= tilt_s5;
				torque <= tq;
				spin_cw <= tq > 32'sd0;
			end else begin
				edge_axis <= '0;
				wheel_select <= '0;
				tilt_error <= '0;
				torque <= '0;
				spin_cw <= 1'b0;
			end
		end
	end
endmodule

// File: rtl/ebt_checker.sv
// ebt_checker: port-level assertions for edge_balance_torque.
// Depends on ebt_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps
module ebt_checker (
	input logic clk,
	input logic arst_n,
	input logic valid_out,
	input logic ready_out,
	input logic ready_in,
	input logic [1:0] status,
	input logic [1:0] edge_axis,
	input logic signed [14:0] tilt_error,
	input logic signed [31:0] torque,
	input logic spin_cw
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !ready_out |=> valid_out && $stable(torque) && $stable(status))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !ready_out |-> !ready_in)
		else $error("request taken while output stalled");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && status != ebt_pkg::ST_EDGE |-> torque == 0 && !spin_cw && edge_axis == 0)
		else $error("fields set off edge");
	a_spin: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> spin_cw == (torque > 0) && tilt_error <= 15'sd12868
		&& tilt_error >= -15'sd12868)
		else $error("spin or tilt range");
endmodule

bind edge_balance_torque ebt_checker u_ebt_checker (
	.clk(clk), .arst_n(arst_n), .valid_out(valid_out), .ready_out(ready_out),
	.ready_in(ready_in), .status(status), .edge_axis(edge_axis),
	.tilt_error(tilt_error), .torque(torque), .spin_cw(spin_cw)
);
